FILE: hw/rtl/ppsh_pkg.sv
// Shared types, codes and widths for the pair separation histogram.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ppsh_pkg;

  // default parameter values
  localparam int DEF_MAX_BINS    = 32;
  localparam int DEF_COUNT_WIDTH = 32;

  // fixed datapath widths
  localparam int CW    = 24;  // coordinate
  localparam int VW    = 25;  // difference / sum component
  localparam int ACCW  = 52;  // squared magnitudes and dot product
  localparam int RW    = 26;  // roots and line-of-sight quotient
  localparam int EW    = 23;  // range edges
  localparam int NBW   = 6;   // bins per axis register
  localparam int IXW   = 10;  // read index field
  localparam int QBW   = 5;   // divider step count
  localparam int PI_QBITS  = 26;
  localparam int BIN_QBITS = 6;

  // command codes
  localparam logic [1:0] CMD_COUNT = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // status codes
  localparam logic [2:0] STAT_COUNTED  = 3'd0;
  localparam logic [2:0] STAT_PROJ_OUT = 3'd1;
  localparam logic [2:0] STAT_LOS_OUT  = 3'd2;
  localparam logic [2:0] STAT_ZERO_SUM = 3'd3;
  localparam logic [2:0] STAT_READ     = 3'd4;
  localparam logic [2:0] STAT_CLEARED  = 3'd5;

  // register indexes
  localparam logic [2:0] REG_NUM_BINS = 3'd0;
  localparam logic [2:0] REG_PROJ_MIN = 3'd1;
  localparam logic [2:0] REG_PROJ_MAX = 3'd2;
  localparam logic [2:0] REG_LOS_MIN  = 3'd3;
  localparam logic [2:0] REG_LOS_MAX  = 3'd4;

  typedef enum logic [1:0] {OP_COUNT, OP_READ, OP_CLEAR} op_t;

  typedef struct packed {
    logic [1:0]             cmd;
    logic signed [CW-1:0]   ax;
    logic signed [CW-1:0]   ay;
    logic signed [CW-1:0]   az;
    logic signed [CW-1:0]   bx;
    logic signed [CW-1:0]   by;
    logic signed [CW-1:0]   bz;
    logic [IXW-1:0]         bin_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  proj_bin;
    logic [4:0]  los_bin;
    logic [31:0] bin_count;
  } out_item_t;

  typedef struct packed {
    op_t                  op;
    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;
    logic signed [VW-1:0] dz;
    logic signed [VW-1:0] sx;
    logic signed [VW-1:0] sy;
    logic signed [VW-1:0] sz;
    logic [IXW-1:0]       bin_index;
  } job_t;

  typedef struct packed {
    logic [NBW-1:0] num_bins;
    logic [EW-1:0]  proj_min;
    logic [EW-1:0]  proj_max;
    logic [EW-1:0]  los_min;
    logic [EW-1:0]  los_max;
  } cfg_t;

  typedef struct packed {
    logic            start;
    logic [ACCW-1:0] dividend;
    logic [RW-1:0]   divisor;
    logic [QBW-1:0]  nbits;
  } div_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [RW-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic            start;
    logic [ACCW-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [RW-1:0] root;
  } sqrt_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ppsh_front.sv
// Input stage: decodes commands, forms difference and sum vectors, queues jobs.
// Depends on ppsh_pkg.
`default_nettype none

module ppsh_front
  import ppsh_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          q_valid,
  output job_t          q_job,
  input  wire logic     q_pop
);

  job_t       fifo [2];
  logic       wrp;
  logic       rdp;
  logic [1:0] cnt;
  logic       push;
  job_t       job_in;

  // decode and form vectors
  always_comb begin
    job_in = '0;
    case (in_data.cmd)
      CMD_COUNT: job_in.op = OP_COUNT;
      CMD_CLEAR: job_in.op = OP_CLEAR;
      default:   job_in.op = OP_READ;
    endcase
    job_in.dx = VW'(in_data.ax) - VW'(in_data.bx);
    job_in.dy = VW'(in_data.ay) - VW'(in_data.by);
    job_in.dz = VW'(in_data.az) - VW'(in_data.bz);
    job_in.sx = VW'(in_data.ax) + VW'(in_data.bx);
    job_in.sy = VW'(in_data.ay) + VW'(in_data.by);
    job_in.sz = VW'(in_data.az) + VW'(in_data.bz);
    job_in.bin_index = in_data.bin_index;
  end

  assign in_stall = (cnt == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt != 2'd0);
  assign q_job    = fifo[rdp];

  // hold queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wrp] <= job_in;
    end
  end

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wrp <= 1'b0;
      rdp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wrp <= ~wrp;
      end
      if (q_pop) begin
        rdp <= ~rdp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ppsh_sqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on ppsh_pkg.
`default_nettype none

module ppsh_sqrt
  import ppsh_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire sqrt_req_t req,
  output sqrt_rsp_t      rsp
);

  localparam logic [ACCW-1:0] BIT0 = ACCW'(1) << (2 * (RW - 1));

  logic [ACCW-1:0] v;
  logic [ACCW-1:0] res;
  logic [ACCW-1:0] bitv;
  logic [QBW-1:0]  cnt;
  logic            busy;
  logic            done;
  logic [ACCW-1:0] trial;

  assign trial = res + bitv;

  // run one digit step per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        v    <= req.radicand;
        res  <= '0;
        bitv <= BIT0;
        cnt  <= QBW'(RW);
        busy <= 1'b1;
      end else if (busy) begin
        if (v >= trial) begin
          v   <= v - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt - QBW'(1);
        if (cnt == QBW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.root = res[RW-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/ppsh_div.sv
// Iterative restoring divider, one quotient bit per cycle, variable bit count.
// Depends on ppsh_pkg.
`default_nettype none

module ppsh_div
  import ppsh_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [ACCW-1:0] rem;
  logic [ACCW-1:0] dsh;
  logic [RW-1:0]   q;
  logic [QBW-1:0]  cnt;
  logic            busy;
  logic            done;

  // shift and subtract one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= req.dividend;
        dsh  <= ACCW'(req.divisor) << (req.nbits - QBW'(1));
        q    <= '0;
        cnt  <= req.nbits;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          q   <= {q[RW-2:0], 1'b1};
        end else begin
          q   <= {q[RW-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt - QBW'(1);
        if (cnt == QBW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = q;

endmodule

`default_nettype wire

FILE: hw/rtl/ppsh_back.sv
// Execution sequencer: magnitudes, roots, binning, counter store and result.
// Depends on ppsh_pkg; drives ppsh_sqrt and ppsh_div requests.
`default_nettype none

module ppsh_back
  import ppsh_pkg::*;
#(
  parameter int MAX_BINS    = DEF_MAX_BINS,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_t      cfg,
  input  wire logic      q_valid,
  input  wire job_t      q_job,
  output logic           q_pop,
  output div_req_t       div_req,
  input  wire div_rsp_t  div_rsp,
  output sqrt_req_t      sqrt_req,
  input  wire sqrt_rsp_t sqrt_rsp,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int DEPTH = MAX_BINS * MAX_BINS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_MUL, S_SQS, S_SQS_WAIT, S_DIVPI, S_DIVPI_WAIT, S_PISQ,
    S_SQR, S_SQR_WAIT, S_BINP, S_BINP_WAIT, S_BINL, S_BINL_WAIT,
    S_MEM_RD, S_MEM_USE, S_RESULT
  } state_t;

  state_t state;

  logic [COUNT_WIDTH-1:0] mem [DEPTH];
  logic [COUNT_WIDTH-1:0] rd_data;
  logic                   mem_we;
  logic [AW-1:0]          mem_wa;
  logic [COUNT_WIDTH-1:0] mem_wd;
  logic                   mem_re;

  job_t                   job;
  logic [AW-1:0]          clr_addr;
  logic                   clr_cmd;
  logic [AW-1:0]          cnt_addr;
  logic [3:0]             mstep;
  logic [3:0]             pstep;
  logic signed [2*VW-1:0] prod;
  logic signed [ACCW-1:0] dot;
  logic signed [ACCW-1:0] dsq;
  logic signed [ACCW-1:0] ssq;
  logic [RW-1:0]          len;
  logic [RW-1:0]          pi;
  logic [ACCW-1:0]        pisq;
  logic [RW-1:0]          rp;
  logic [NBW-1:0]         kp;
  logic [2:0]             res_status;
  logic [4:0]             res_pb;
  logic [4:0]             res_lb;
  logic [31:0]            res_cnt;

  logic [NBW-1:0]         nb;
  logic signed [VW-1:0]   ma;
  logic signed [VW-1:0]   mb;
  logic [ACCW-1:0]        adot;
  logic [ACCW-1:0]        rpsq;
  logic [RW-1:0]          bv;
  logic [RW-1:0]          blo;
  logic [RW-1:0]          bhi;
  logic                   bin_out;
  logic [31:0]            bin_num;
  logic [11:0]            hidx;
  logic [31:0]            hidx32;
  logic [31:0]            ridx32;
  logic                   ridx_ok;
  logic [63:0]            rd64;
  logic [31:0]            rd_sat;
  logic                   out_free;
  logic                   out_load;

  // effective bins per axis
  always_comb begin
    if (cfg.num_bins == '0) begin
      nb = NBW'(1);
    end else if ({1'b0, cfg.num_bins} > (NBW + 1)'(MAX_BINS)) begin
      nb = NBW'(MAX_BINS);
    end else begin
      nb = cfg.num_bins;
    end
  end

  // select multiplier operands: dot, then |d|^2, then |s|^2
  always_comb begin
    case (mstep)
      4'd0:    begin ma = job.dx; mb = job.sx; end
      4'd1:    begin ma = job.dy; mb = job.sy; end
      4'd2:    begin ma = job.dz; mb = job.sz; end
      4'd3:    begin ma = job.dx; mb = job.dx; end
      4'd4:    begin ma = job.dy; mb = job.dy; end
      4'd5:    begin ma = job.dz; mb = job.dz; end
      4'd6:    begin ma = job.sx; mb = job.sx; end
      4'd7:    begin ma = job.sy; mb = job.sy; end
      default: begin ma = job.sz; mb = job.sz; end
    endcase
  end

  assign adot = dot[ACCW-1] ? ACCW'(-dot) : ACCW'(dot);
  assign rpsq = (ACCW'(dsq) > pisq) ? (ACCW'(dsq) - pisq) : '0;

  // shared binning check for both axes
  always_comb begin
    if (state == S_BINL) begin
      bv  = pi;
      blo = RW'(cfg.los_min);
      bhi = RW'(cfg.los_max);
    end else begin
      bv  = rp;
      blo = RW'(cfg.proj_min);
      bhi = RW'(cfg.proj_max);
    end
    bin_out = (bhi <= blo) || (bv < blo) || (bv >= bhi);
    bin_num = 32'(bv - blo) * 32'(nb);
  end

  assign hidx    = 12'(kp) * 12'(nb) + 12'(div_rsp.quot[NBW-1:0]);
  assign hidx32  = 32'(hidx);
  assign ridx32  = 32'(q_job.bin_index);
  assign ridx_ok = ridx32 < 32'(DEPTH);
  assign rd64    = 64'(rd_data);
  assign rd_sat  = (rd64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rd64[31:0];

  // shared unit requests
  always_comb begin
    div_req        = '0;
    sqrt_req       = '0;
    case (state)
      S_SQS: begin
        sqrt_req.start    = 1'b1;
        sqrt_req.radicand = ACCW'(ssq);
      end
      S_SQR: begin
        sqrt_req.start    = 1'b1;
        sqrt_req.radicand = rpsq;
      end
      S_DIVPI: begin
        div_req.start    = 1'b1;
        div_req.dividend = adot;
        div_req.divisor  = len;
        div_req.nbits    = QBW'(PI_QBITS);
      end
      S_BINP, S_BINL: begin
        div_req.start    = !bin_out;
        div_req.dividend = ACCW'(bin_num);
        div_req.divisor  = bhi - blo;
        div_req.nbits    = QBW'(BIN_QBITS);
      end
      default: begin
      end
    endcase
  end

  // memory port controls
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_addr;
    mem_wd = '0;
    mem_re = (state == S_MEM_RD);
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_MEM_USE && job.op == OP_COUNT) begin
      mem_we = 1'b1;
      mem_wa = cnt_addr;
      mem_wd = (rd_data == '1) ? rd_data : rd_data + COUNT_WIDTH'(1);
    end
  end

  // counter store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[cnt_addr];
    end
  end

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == S_RESULT) && out_free;

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_cmd   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= (clr_addr == LAST_ADDR) ? '0 : clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            res_status <= STAT_CLEARED;
            state      <= clr_cmd ? S_RESULT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            job        <= q_job;
            res_status <= STAT_READ;
            res_pb     <= '0;
            res_lb     <= '0;
            res_cnt    <= '0;
            case (q_job.op)
              OP_COUNT: begin
                mstep <= '0;
                dot   <= '0;
                dsq   <= '0;
                ssq   <= '0;
                state <= S_MUL;
              end
              OP_CLEAR: begin
                clr_addr <= '0;
                clr_cmd  <= 1'b1;
                state    <= S_CLEAR;
              end
              default: begin
                cnt_addr <= ridx32[AW-1:0];
                state    <= ridx_ok ? S_MEM_RD : S_RESULT;
              end
            endcase
          end
        end
        S_MUL: begin
          prod  <= ma * mb;
          pstep <= mstep;
          mstep <= mstep + 4'd1;
          if (mstep != 4'd0) begin
            if (pstep < 4'd3) begin
              dot <= dot + ACCW'(prod);
            end else if (pstep < 4'd6) begin
              dsq <= dsq + ACCW'(prod);
            end else begin
              ssq <= ssq + ACCW'(prod);
            end
          end
          if (mstep == 4'd9) begin
            state <= S_SQS;
          end
        end
        S_SQS: state <= S_SQS_WAIT;
        S_SQS_WAIT: begin
          if (sqrt_rsp.done) begin
            len <= sqrt_rsp.root;
            if (sqrt_rsp.root == '0) begin
              res_status <= STAT_ZERO_SUM;
              state      <= S_RESULT;
            end else begin
              state <= S_DIVPI;
            end
          end
        end
        S_DIVPI: state <= S_DIVPI_WAIT;
        S_DIVPI_WAIT: begin
          if (div_rsp.done) begin
            pi    <= div_rsp.quot;
            state <= S_PISQ;
          end
        end
        S_PISQ: begin
          pisq  <= ACCW'(pi) * ACCW'(pi);
          state <= S_SQR;
        end
        S_SQR: state <= S_SQR_WAIT;
        S_SQR_WAIT: begin
          if (sqrt_rsp.done) begin
            rp    <= sqrt_rsp.root;
            state <= S_BINP;
          end
        end
        S_BINP: begin
          if (bin_out) begin
            res_status <= STAT_PROJ_OUT;
            state      <= S_RESULT;
          end else begin
            state <= S_BINP_WAIT;
          end
        end
        S_BINP_WAIT: begin
          if (div_rsp.done) begin
            kp    <= div_rsp.quot[NBW-1:0];
            state <= S_BINL;
          end
        end
        S_BINL: begin
          if (bin_out) begin
            res_status <= STAT_LOS_OUT;
            state      <= S_RESULT;
          end else begin
            state <= S_BINL_WAIT;
          end
        end
        S_BINL_WAIT: begin
          if (div_rsp.done) begin
            res_pb   <= kp[4:0];
            res_lb   <= div_rsp.quot[4:0];
            cnt_addr <= hidx32[AW-1:0];
            state    <= S_MEM_RD;
          end
        end
        S_MEM_RD: state <= S_MEM_USE;
        S_MEM_USE: begin
          if (job.op == OP_COUNT) begin
            res_status <= STAT_COUNTED;
          end else begin
            res_cnt <= rd_sat;
          end
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            out_data.status    <= res_status;
            out_data.proj_bin  <= (res_status == STAT_COUNTED) ? res_pb : 5'd0;
            out_data.los_bin   <= (res_status == STAT_COUNTED) ? res_lb : 5'd0;
            out_data.bin_count <= res_cnt;
            clr_cmd            <= 1'b0;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // pop only from a non-empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue popped while empty");

  // shared units are never restarted mid-run
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_sqrt_free: assert property (@(posedge clk) disable iff (rst)
    sqrt_req.start |-> !sqrt_rsp.busy)
    else $error("square root started while busy");

  // a loaded result is presented on the next cycle
  a_out_load: assert property (@(posedge clk) disable iff (rst) out_load |=> out_valid)
    else $error("result load lost");

endmodule

`default_nettype wire

FILE: hw/rtl/projected_pair_separation_histogram.sv
// Pair separation histogram: a counted pair goes through the pop, the multiply
// steps, a square root of the sum, the line-of-sight divide, pi squared, a second
// square root, a bin divide per axis, then counter update and result; the sequencer
// ends one item before it pops the next. A zero sum vector returns after the first square root.
// A read skips the arithmetic. A clear command sweeps the store one entry a cycle.
// Synchronous reset: registers return to defaults and the same clearing sweep
// runs; inputs queue up but no item completes during it.
`default_nettype none

module projected_pair_separation_histogram
  import ppsh_pkg::*;
#(
  parameter int MAX_BINS    = DEF_MAX_BINS,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire in_item_t      in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output out_item_t          out_data,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [EW-1:0] cfg_data
);

  cfg_t      cfg;
  logic      q_valid;
  job_t      q_job;
  logic      q_pop;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_bins <= NBW'(32);
      cfg.proj_min <= '0;
      cfg.proj_max <= EW'(10240);
      cfg.los_min  <= '0;
      cfg.los_max  <= EW'(10240);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_BINS: cfg.num_bins <= cfg_data[NBW-1:0];
        REG_PROJ_MIN: cfg.proj_min <= cfg_data;
        REG_PROJ_MAX: cfg.proj_max <= cfg_data;
        REG_LOS_MIN:  cfg.los_min  <= cfg_data;
        REG_LOS_MAX:  cfg.los_max  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ppsh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .q_pop    (q_pop)
  );

  ppsh_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sqrt_req),
    .rsp (sqrt_rsp)
  );

  ppsh_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  ppsh_back #(
    .MAX_BINS    (MAX_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .sqrt_req  (sqrt_req),
    .sqrt_rsp  (sqrt_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: bench/tb_projected_pair_separation_histogram.sv
// Self-checking bench for the projected / line-of-sight pair separation histogram.
// Depends on ppsh_pkg and projected_pair_separation_histogram; it predicts every
// result in-bench and compares transfers in order.
`timescale 1ns / 100ps

module tb_projected_pair_separation_histogram;
  import ppsh_pkg::*;

  localparam int HIST_DEPTH = 1024;
  localparam int BIN_CAP    = 32;
  localparam int SETTLE     = 1300;     // clear sweep plus a count in flight
  localparam int LIMIT      = 2000000;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  logic      clk = 0;
  logic      rst = 1;
  logic      in_valid = 0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 0;
  out_item_t out_data;
  logic      cfg_we = 0;
  logic [2:0] cfg_index = REG_NUM_BINS;
  logic [EW-1:0] cfg_data = '0;

  projected_pair_separation_histogram uut (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_index, .cfg_data
  );

  always #6 clk = ~clk;

  // predictor state
  logic [31:0]   counters [HIST_DEPTH];
  logic [5:0]    nb_reg = 6'd32;
  logic [EW-1:0] rp_lo = '0, rp_hi = EW'(10240), pi_lo = '0, pi_hi = EW'(10240);
  logic [9:0]    last_hit = '0;

  in_item_t  pending_q [$];
  out_item_t result_q [$];

  int errors = 0, cycles = 0, transfers_in = 0, transfers_out = 0;
  int n_counted = 0, n_reads = 0, n_clears = 0, n_flagged = 0;
  bit in_took = 0, out_took = 0, quiet = 0;
  int send_gap = 0, recv_gap = 0, hold_left = 0;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root, bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // bin v over [lo, hi); returns 0 when outside
  function automatic bit to_bin(logic [63:0] v, logic [63:0] lo, logic [63:0] hi,
                                logic [63:0] nb, output logic [63:0] k);
    k = '0;
    if (hi <= lo || v < lo) return 0;
    k = ((v - lo) * nb) / (hi - lo);
    return k < nb;
  endfunction

  function automatic out_item_t histogram_step(in_item_t it);
    out_item_t r;
    longint dx, dy, dz, sx, sy, sz, dot;
    logic [63:0] dsq, ssq, adot, len, nb, pi, pisq, rp, kp, kl, idx;
    r = '0;
    if (it.cmd == CMD_CLEAR) begin
      foreach (counters[i]) counters[i] = '0;
      r.status = STAT_CLEARED;
      n_clears++;
    end else if (it.cmd == CMD_READ || it.cmd == CMD_SPARE) begin
      r.status = STAT_READ;
      r.bin_count = counters[it.bin_index];
      n_reads++;
    end else begin
      dx = longint'($signed(it.ax)) - longint'($signed(it.bx));
      dy = longint'($signed(it.ay)) - longint'($signed(it.by));
      dz = longint'($signed(it.az)) - longint'($signed(it.bz));
      sx = longint'($signed(it.ax)) + longint'($signed(it.bx));
      sy = longint'($signed(it.ay)) + longint'($signed(it.by));
      sz = longint'($signed(it.az)) + longint'($signed(it.bz));
      dot = dx * sx + dy * sy + dz * sz;
      dsq = dx * dx + dy * dy + dz * dz;
      ssq = sx * sx + sy * sy + sz * sz;
      adot = dot < 0 ? -dot : dot;
      len = int_sqrt(ssq);
      if (nb_reg == 6'd0) nb = 64'd1;
      else if (64'(nb_reg) > 64'(BIN_CAP)) nb = 64'(BIN_CAP);
      else nb = 64'(nb_reg);
      if (len == 0) begin
        r.status = STAT_ZERO_SUM;
        n_flagged++;
        return r;
      end
      pi = adot / len;
      pisq = pi * pi;
      rp = (dsq > pisq) ? int_sqrt(dsq - pisq) : 64'd0;
      if (!to_bin(rp, 64'(rp_lo), 64'(rp_hi), nb, kp)) begin
        r.status = STAT_PROJ_OUT;
        n_flagged++;
      end else if (!to_bin(pi, 64'(pi_lo), 64'(pi_hi), nb, kl)) begin
        r.status = STAT_LOS_OUT;
        n_flagged++;
      end else begin
        idx = kp * nb + kl;
        if (counters[idx] != 32'hFFFF_FFFF) counters[idx]++;
        last_hit = idx[9:0];
        r.status = STAT_COUNTED;
        r.proj_bin = kp[4:0];
        r.los_bin = kl[4:0];
        n_counted++;
      end
    end
    return r;
  endfunction

  // sample transfers, predict on input, compare on output
  always @(posedge clk) begin
    out_item_t want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
    in_took = !rst && in_valid && !in_stall;
    out_took = !rst && out_valid && !out_stall;
    if (in_took) begin
      result_q.push_back(histogram_step(in_data));
      transfers_in++;
    end
    if (out_took) begin
      transfers_out++;
      if (result_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result %p", out_data);
      end else begin
        want = result_q.pop_front();
        if (out_data !== want) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch at result %0d: expected %p, got %p",
                     transfers_out, want, out_data);
        end
      end
    end
  end

  // sender: hold a stalled transfer, otherwise advance or idle
  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 0;
      end else if (pending_q.size() > 0) begin
        in_data <= pending_q.pop_front();
        in_valid <= 1;
        if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 18);
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver: long hold-off when asked, else random stall bursts
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall <= 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(0, 17);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [EW-1:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_NUM_BINS: nb_reg = val[5:0];
      REG_PROJ_MIN: rp_lo = val;
      REG_PROJ_MAX: rp_hi = val;
      REG_LOS_MIN:  pi_lo = val;
      REG_LOS_MAX:  pi_hi = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_ranges(int nb, int p0, int p1, int l0, int l1);
    write_reg(REG_NUM_BINS, EW'(nb));
    write_reg(REG_PROJ_MIN, EW'(p0));
    write_reg(REG_PROJ_MAX, EW'(p1));
    write_reg(REG_LOS_MIN, EW'(l0));
    write_reg(REG_LOS_MAX, EW'(l1));
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !in_valid && result_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic in_item_t pair_item(logic [1:0] cmd, int ax, int ay, int az,
                                         int bx, int by, int bz, int idx);
    in_item_t it;
    it.cmd = cmd;
    it.ax = CW'(ax); it.ay = CW'(ay); it.az = CW'(az);
    it.bx = CW'(bx); it.by = CW'(by); it.bz = CW'(bz);
    it.bin_index = IXW'(idx);
    return it;
  endfunction

  function automatic int edge_coord();
    case ($urandom_range(0, 3))
      0: return -8388608;
      1: return 8388607;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  function automatic int near_off(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int ax, ay, az, sel;
    it = pair_item(CMD_COUNT, 0, 0, 0, 0, 0, 0, $urandom_range(0, 1023));
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      it.cmd = CMD_READ;
      if ($urandom_range(0, 1)) it.bin_index = last_hit;
      return it;
    end
    if (sel < 18) begin
      it.cmd = CMD_SPARE;
      return it;
    end
    if (sel < 19) begin
      it.cmd = CMD_CLEAR;
      return it;
    end
    ax = near_off(4194303);
    ay = near_off(4194303);
    az = near_off(4194303);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: it = pair_item(CMD_COUNT, ax, ay, az, ax + near_off(6000),
                                       ay + near_off(6000), az + near_off(6000), 0);
      6: it = pair_item(CMD_COUNT, ax, ay, az, -ax, -ay, -az, 0);
      7: it = pair_item(CMD_COUNT, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, 0);
      8: it = pair_item(CMD_COUNT, near_off(300), near_off(300), near_off(300),
                        near_off(300), near_off(300), near_off(300), 0);
      default: it = pair_item(CMD_COUNT, edge_coord(), edge_coord(), edge_coord(),
                              edge_coord(), edge_coord(), edge_coord(), 0);
    endcase
    it.bin_index = IXW'($urandom);
    return it;
  endfunction

  task automatic random_phase(int n);
    repeat (n) pending_q.push_back(random_item());
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: extremes, zero sum, every command, large index, spare command
    pending_q.push_back(pair_item(CMD_COUNT, -8388608, -8388608, -8388608,
                                  8388607, 8388607, 8388607, 0));
    pending_q.push_back(pair_item(CMD_COUNT, 8388607, 8388607, 8388607,
                                  -8388608, -8388608, -8388608, 0));
    pending_q.push_back(pair_item(CMD_COUNT, -8388608, -8388608, -8388608,
                                  -8388608, -8388608, -8388608, 0));
    pending_q.push_back(pair_item(CMD_COUNT, 8388607, 8388607, 8388607,
                                  8388607, 8388607, 8388607, 0));
    pending_q.push_back(pair_item(CMD_COUNT, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(pair_item(CMD_COUNT, 5000, -7000, 300, -5000, 7000, -300, 0));
    pending_q.push_back(pair_item(CMD_COUNT, 256000, 0, 0, 255000, 0, 0, 0));
    pending_q.push_back(pair_item(CMD_COUNT, 256000, 0, 0, 256000, 1000, 0, 0));
    pending_q.push_back(pair_item(CMD_COUNT, 256000, 0, 0, 256000, 1000, 0, 0));
    pending_q.push_back(pair_item(CMD_COUNT, 1, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(pair_item(CMD_COUNT, 100000, 2000, 0, 90000, -2000, 0, 0));
    pending_q.push_back(pair_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(pair_item(CMD_READ, 0, 0, 0, 0, 0, 0, 4 * 32));
    pending_q.push_back(pair_item(CMD_READ, 0, 0, 0, 0, 0, 0, 1023));
    pending_q.push_back(pair_item(CMD_SPARE, 0, 0, 0, 0, 0, 0, 4 * 32));
    pending_q.push_back(pair_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(pair_item(CMD_READ, 0, 0, 0, 0, 0, 0, 4 * 32));
    drain();

    // defaults, with a long receiver hold-off so the block backs up
    hold_left = 600;
    random_phase(150);
    set_ranges(1, 0, 10240, 0, 10240);
    random_phase(120);
    set_ranges(0, 512, 4096, 256, 2048);
    random_phase(120);
    set_ranges(63, 0, 8388607, 0, 8388607);
    random_phase(140);
    // empty ranges on either axis
    set_ranges(7, 4000, 4000, 0, 10240);
    random_phase(80);
    set_ranges(7, 0, 10240, 9000, 100);
    random_phase(80);
    set_ranges($urandom_range(1, 32), $urandom_range(0, 2000), $urandom_range(3000, 20000),
               $urandom_range(0, 2000), $urandom_range(3000, 20000));
    random_phase(160);
    set_ranges(32, 8388607, 8388607, 0, 8388606);
    random_phase(60);
    set_ranges(16, 0, 12000, 0, 12000);
    random_phase(100);
    quiet = 1;
    random_phase(120);

    $display("Transfers in %0d, out %0d: %0d counted, %0d flagged, %0d reads, %0d clears",
             transfers_in, transfers_out, n_counted, n_flagged, n_reads, n_clears);
    $display("Covered bin settings 0, 1, 7, 16, 32, 63, empty ranges and stall pressure");
    if (errors == 0 && result_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Errors %0d, results still owed %0d", errors, result_q.size());
      $display("Some tests failed");
    end
    $finish;
  end

  initial foreach (counters[i]) counters[i] = '0;

endmodule
